// ===== sv/aesc_pkg.sv =====
// ----------------------------------------------------------------------------
// aesc_pkg: shared constants and functions for the AES ECB/CBC core
// S-box tables, GF(2^8) helpers and register indexes.
// ----------------------------------------------------------------------------
package aesc_pkg;

	localparam int RK_WORDS = 60;
	localparam int RK_AW    = 6;

	localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] REG_KEY_BITS_0 = 3'd1;
	localparam logic [2:0] REG_KEY_BITS_1 = 3'd2;
	localparam logic [2:0] REG_KEY_BITS_2 = 3'd3;
	localparam logic [2:0] REG_KEY_BITS_3 = 3'd4;
	localparam logic [2:0] REG_CHAIN_MODE = 3'd5;
	localparam logic [2:0] REG_DIRECTION  = 3'd6;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] p;
		logic [7:0] b;
		logic [7:0] x;
		// a^254 by square and multiply
		r = 8'h01;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (k != 0) begin
				p = 8'h00;
				b = x;
				for (int j = 0; j < 8; j++) begin
					if (r[j]) p = p ^ b;
					b = xtime(b);
				end
				r = p;
			end
			p = 8'h00;
			b = x;
			for (int j = 0; j < 8; j++) begin
				if (x[j]) p = p ^ b;
				b = xtime(b);
			end
			x = p;
		end
		gf_inv = r;
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] a);
		logic [7:0] q;
		q = gf_inv(a);
		sbox_calc = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
			^ {q[3:0], q[7:4]} ^ 8'h63;
	endfunction

	typedef logic [7:0] byte_tab_t [256];

	function automatic byte_tab_t build_sbox();
		byte_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
		return t;
	endfunction

	function automatic byte_tab_t build_inv();
		byte_tab_t t;
		for (int i = 0; i < 256; i++) t[sbox_calc(8'(i))] = 8'(i);
		return t;
	endfunction

	localparam byte_tab_t SBOX     = build_sbox();
	localparam byte_tab_t INV_SBOX = build_inv();

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// one column of mix columns, forward or inverse
	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] o [4];
		for (int r = 0; r < 4; r++) begin
			a[r]  = c[31-8*r -: 8];
			a2[r] = xtime(a[r]);
			a4[r] = xtime(a2[r]);
			a8[r] = xtime(a4[r]);
		end
		for (int r = 0; r < 4; r++) begin
			if (inv)
				o[r] = (a8[r] ^ a4[r] ^ a2[r])
					^ (a8[(r+1)%4] ^ a2[(r+1)%4] ^ a[(r+1)%4])
					^ (a8[(r+2)%4] ^ a4[(r+2)%4] ^ a[(r+2)%4])
					^ (a8[(r+3)%4] ^ a[(r+3)%4]);
			else
				o[r] = a2[r] ^ a2[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
		end
		mix_col = {o[0], o[1], o[2], o[3]};
	endfunction

endpackage

// ===== sv/aes_block_cipher_ecb_cbc_core.sv =====
// ----------------------------------------------------------------------------
// aes_block_cipher_ecb_cbc_core: AES-128/192/256 block cipher, ECB or CBC
// Expands the key into a round-key RAM, then processes one block per item,
// substituting a byte per cycle through a 16-byte shift register.
// ----------------------------------------------------------------------------
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid in_ready block_high block_low new_message | sink
//  out     | out_valid out_ready result_high result_low         | source
//  cfg     | psel penable pwrite paddr pwdata prdata pready     | APB slave
//
// Sequence: after a key write the first item first loads the nk raw key words
// (one per step), then derives each of the remaining words (up to 52) through
// the read, read and write steps. A block then passes a read-priming step and
// 4 column steps of key add per round key, 16 byte steps of the S-box and
// 4 column steps of mix columns per round (no mix in the last one), and a
// final step that loads the result into the output register.
// Reset clears control and the chain; the round-key RAM needs no clearing.
// A finished result sits in the output register while the next item is taken
// and processed; that item holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module aes_block_cipher_ecb_cbc_core
	import aesc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [63:0]  block_high,
	input  logic [63:0]  block_low,
	input  logic         new_message,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [63:0]  result_high,
	output logic [63:0]  result_low
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_KLOAD = 4'd1;  // write raw key words
	localparam logic [3:0] ST_KRD   = 4'd2;  // read w[i-1]
	localparam logic [3:0] ST_KRD2  = 4'd3;  // read w[i-nk]
	localparam logic [3:0] ST_KWR   = 4'd4;  // write w[i]
	localparam logic [3:0] ST_ARK   = 4'd5;  // read round key words
	localparam logic [3:0] ST_ARKW  = 4'd6;  // xor one column per cycle
	localparam logic [3:0] ST_SUB   = 4'd7;  // byte-serial sub bytes
	localparam logic [3:0] ST_MIX   = 4'd8;  // column-serial mix columns
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [1:0]  key_length_q;
	logic [63:0] key_q [4];
	logic        chain_mode_q, direction_q, keys_ready_q;
	logic [63:0] chain_q [2];

	logic [3:0]  state_q;
	logic [5:0]  idx_q;       // key word index
	logic [3:0]  rnd_q;       // current round number
	logic [4:0]  cnt_q;       // byte or column step
	logic [7:0]  rc_q;
	logic [31:0] prev_q;
	logic [127:0] st_q;
	logic [127:0] inb_q;
	logic        out_valid_q;
	logic [127:0] res_q;

	logic        cfg_wr;
	logic [2:0]  cfg_idx;
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[5:3];

	always_comb begin
		case (cfg_idx)
			REG_KEY_LENGTH: prdata = {62'd0, key_length_q};
			REG_KEY_BITS_0: prdata = key_q[0];
			REG_KEY_BITS_1: prdata = key_q[1];
			REG_KEY_BITS_2: prdata = key_q[2];
			REG_KEY_BITS_3: prdata = key_q[3];
			REG_CHAIN_MODE: prdata = {63'd0, chain_mode_q};
			REG_DIRECTION:  prdata = {63'd0, direction_q};
			default:        prdata = 64'd0;
		endcase
	end

	// key geometry
	logic [3:0] nk;
	logic [3:0] nrounds;
	logic [5:0] total;
	always_comb begin
		case (key_length_q)
			2'd0:    nk = 4'd4;
			2'd1:    nk = 4'd6;
			default: nk = 4'd8;
		endcase
		nrounds = nk + 4'd6;
		total   = 6'({nrounds, 2'b00} + 6'd4);
	end

	// i mod nk by small compare chain: track phase alongside idx
	logic [3:0] ph_q;

	// RAM
	logic        ram_we;
	logic [5:0]  ram_wa, ram_ra;
	logic [31:0] ram_wd, ram_rd;
	aesc_ram #(.WIDTH(32), .DEPTH(RK_WORDS)) u_rk (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic [31:0] raw_word;
	always_comb begin
		raw_word = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];
	end

	// expansion temp
	logic [31:0] kx_t;
	always_comb begin
		if (ph_q == 4'd0)
			kx_t = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rc_q, 24'd0};
		else if (nk == 4'd8 && ph_q == 4'd4)
			kx_t = sub_word(prev_q);
		else
			kx_t = prev_q;
	end

	// byte-serial S-box on the head byte of the state
	logic [7:0] sb_in, sb_out;
	assign sb_in  = st_q[127:120];
	assign sb_out = direction_q ? INV_SBOX[sb_in] : SBOX[sb_in];

	// shift rows (pure wiring), applied once the 16 bytes are substituted
	function automatic logic [127:0] shrows(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (inv)
					t[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
				else
					t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
			end
		return t;
	endfunction

	logic [31:0] mc_out;
	assign mc_out = mix_col(st_q[127:96], direction_q);

	logic [127:0] chain_blk;
	assign chain_blk = {chain_q[0], chain_q[1]};

	logic in_acc;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;

	// the last step may load the output register once it is free or being read
	logic done_go;
	assign done_go = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// round key word address for the current round and column
	logic [5:0] rk_addr;
	assign rk_addr = 6'({rnd_q, 2'b00}) + 6'(cnt_q[1:0]);

	logic last_round;
	assign last_round = direction_q ? (rnd_q == 4'd0) : (rnd_q == nrounds);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = idx_q;
		ram_wd = raw_word;
		ram_ra = idx_q;
		case (state_q)
			ST_KLOAD: ram_we = 1'b1;
			ST_KRD:   ram_ra = 6'(idx_q - 6'd1);
			ST_KRD2:  ram_ra = 6'(idx_q - 6'(nk));
			ST_KWR: begin
				ram_we = 1'b1;
				ram_wd = ram_rd ^ kx_t;
			end
			ST_ARK, ST_ARKW: ram_ra = rk_addr;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= 2'd0;
			for (int i = 0; i < 4; i++) key_q[i] <= 64'd0;
			chain_mode_q <= 1'b0;
			direction_q  <= 1'b0;
			keys_ready_q <= 1'b0;
			chain_q[0]   <= 64'd0;
			chain_q[1]   <= 64'd0;
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			idx_q        <= 6'd0;
			rnd_q        <= 4'd0;
			cnt_q        <= 5'd0;
			ph_q         <= 4'd0;
			rc_q         <= 8'h01;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_KEY_LENGTH: begin
						key_length_q <= pwdata[1:0];
						keys_ready_q <= 1'b0;
					end
					REG_KEY_BITS_0: begin key_q[0] <= pwdata; keys_ready_q <= 1'b0; end
					REG_KEY_BITS_1: begin key_q[1] <= pwdata; keys_ready_q <= 1'b0; end
					REG_KEY_BITS_2: begin key_q[2] <= pwdata; keys_ready_q <= 1'b0; end
					REG_KEY_BITS_3: begin key_q[3] <= pwdata; keys_ready_q <= 1'b0; end
					REG_CHAIN_MODE: chain_mode_q <= pwdata[0];
					REG_DIRECTION:  direction_q  <= pwdata[0];
					default: ;
				endcase
			end
			if (done_go) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						// drop the chain on a new message, then pre-whiten
						inb_q <= {block_high, block_low};
						if (new_message) begin
							chain_q[0] <= 64'd0;
							chain_q[1] <= 64'd0;
						end
						if (!direction_q && chain_mode_q && !new_message)
							st_q <= {block_high, block_low} ^ chain_blk;
						else
							st_q <= {block_high, block_low};
						rnd_q <= direction_q ? nrounds : 4'd0;
						cnt_q <= 5'd0;
						idx_q <= 6'd0;
						if (keys_ready_q) state_q <= ST_ARK;
						else state_q <= ST_KLOAD;
					end
				end
				ST_KLOAD: begin
					if (idx_q == 6'(nk) - 6'd1) begin
						ph_q  <= 4'd0;
						rc_q  <= 8'h01;
						state_q <= ST_KRD;
					end
					idx_q <= idx_q + 6'd1;
				end
				ST_KRD: state_q <= ST_KRD2;
				ST_KRD2: begin
					prev_q  <= ram_rd;
					state_q <= ST_KWR;
				end
				ST_KWR: begin
					if (ph_q == 4'd0) rc_q <= xtime(rc_q);
					ph_q  <= (ph_q == nk - 4'd1) ? 4'd0 : ph_q + 4'd1;
					idx_q <= idx_q + 6'd1;
					if (idx_q == total - 6'd1) begin
						keys_ready_q <= 1'b1;
						state_q      <= ST_ARK;
					end else begin
						state_q <= ST_KRD;
					end
				end
				ST_ARK: begin
					// prime the read port with the first column's word
					cnt_q   <= 5'd1;
					state_q <= ST_ARKW;
				end
				ST_ARKW: begin
					// xor the head column and rotate by one column
					st_q <= {st_q[95:0], st_q[127:96] ^ ram_rd};
					if (cnt_q == 5'd4) begin
						cnt_q <= 5'd0;
						if (last_round) state_q <= ST_DONE;
						else if (direction_q && rnd_q != nrounds) state_q <= ST_MIX;
						else state_q <= ST_SUB;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SUB: begin
					if (cnt_q == 5'd15) begin
						st_q  <= shrows({st_q[119:0], sb_out}, direction_q);
						cnt_q <= 5'd0;
						rnd_q <= direction_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
						if (!direction_q && rnd_q + 4'd1 != nrounds) state_q <= ST_MIX;
						else state_q <= ST_ARK;
					end else begin
						st_q  <= {st_q[119:0], sb_out};
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_MIX: begin
					st_q <= {st_q[95:0], mc_out};
					if (cnt_q == 5'd3) begin
						cnt_q   <= 5'd0;
						state_q <= direction_q ? ST_SUB : ST_ARK;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DONE: begin
					// hold until the output register frees up
					if (done_go) begin
						// post-whiten on decrypt, load the chain with the ciphertext
						if (direction_q) begin
							res_q <= chain_mode_q ? (st_q ^ chain_blk) : st_q;
							chain_q[0] <= inb_q[127:64];
							chain_q[1] <= inb_q[63:0];
						end else begin
							res_q <= st_q;
							chain_q[0] <= st_q[127:64];
							chain_q[1] <= st_q[63:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign result_high = res_q[127:64];
	assign result_low  = res_q[63:0];

endmodule

// ===== sv/aesc_ram.sv =====
// ----------------------------------------------------------------------------
// aesc_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aesc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 60,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
